### hdl/afa_pkg.sv
// Package for the accelerometer frame aligner: word type, stage codes and
// queue sizing shared by the front end, the word queue and the back end.
// Depends on nothing.
package afa_pkg;

  localparam int SAMPLE_W     = 20;
  localparam int BYTE_W       = 8;
  localparam int MARK_POS     = 0;
  localparam int QUEUE_DEPTH  = 2;
  localparam int QUEUE_PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CNT_W  = $clog2(QUEUE_DEPTH + 1);

  // Byte position inside a 24-bit word
  typedef enum logic [1:0] {
    PHASE_HIGH = 2'd0,
    PHASE_MID  = 2'd1,
    PHASE_LOW  = 2'd2
  } afa_phase_t;

  // Axis sequence stage of the back end
  typedef enum logic [1:0] {
    STAGE_IDLE   = 2'd0,
    STAGE_FULL   = 2'd1,
    STAGE_WANT_Y = 2'd2,
    STAGE_WANT_Z = 2'd3
  } afa_stage_t;

  // One classified word passed from front to back
  typedef struct packed {
    logic                marked;
    logic [SAMPLE_W-1:0] sample;
  } afa_word_t;

endpackage

### hdl/afa_ifs.sv
// Stream interfaces of the frame aligner: the byte input channel and the
// result output channel, each a valid/ready handshake with its payload.
// Depends on nothing.
interface afa_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;

  modport source (output valid, data_byte, restart, input ready);
  modport sink   (input valid, data_byte, restart, output ready);
endinterface

interface afa_result_if;
  logic               valid;
  logic               ready;
  logic               triplet_valid;
  logic               sync_error;
  logic signed [19:0] x_value;
  logic signed [19:0] y_value;
  logic signed [19:0] z_value;

  modport source (output valid, triplet_valid, sync_error, x_value, y_value, z_value,
                  input ready);
  modport sink   (input valid, triplet_valid, sync_error, x_value, y_value, z_value,
                  output ready);
endinterface

### hdl/afa_front.sv
// Front end of the frame aligner: gathers bytes into 24-bit words and
// classifies each word by its axis mark. Depends on afa_pkg and afa_byte_if.
module afa_front
  import afa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  afa_byte_if.sink      byte_stream,
  input  logic          queue_full,
  output logic          push,
  output afa_word_t     push_word
);

  afa_phase_t  phase;
  afa_phase_t  phase_next;
  afa_phase_t  phase_eff;
  logic [7:0]  high_byte;
  logic [7:0]  mid_byte;
  logic        take;

  // Accept a byte whenever the queue has room for a finished word
  assign byte_stream.ready = !queue_full;
  assign take = byte_stream.valid && byte_stream.ready;

  // Restart realigns to the high byte before this byte is taken
  assign phase_eff = byte_stream.restart ? PHASE_HIGH : phase;

  // Advance the byte phase; an unused code counts as the high byte
  always_comb begin
    case (phase_eff)
      PHASE_HIGH: phase_next = PHASE_MID;
      PHASE_MID:  phase_next = PHASE_LOW;
      PHASE_LOW:  phase_next = PHASE_HIGH;
      default:    phase_next = PHASE_MID;
    endcase
  end

  // Hand a finished word to the queue on its low byte
  always_comb begin
    push             = take && (phase_eff == PHASE_LOW);
    push_word.marked = byte_stream.data_byte[MARK_POS];
    push_word.sample = {high_byte, mid_byte, byte_stream.data_byte[7:4]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PHASE_HIGH;
    end else if (take) begin
      phase <= phase_next;
    end
  end

  // Hold the leading bytes of the word under construction
  always_ff @(posedge clk) begin
    if (take) begin
      case (phase_eff)
        PHASE_MID:  mid_byte  <= byte_stream.data_byte;
        PHASE_LOW:  ;
        default:    high_byte <= byte_stream.data_byte;
      endcase
    end
  end

endmodule

### hdl/afa_word_queue.sv
// Short word queue between the front and back ends of the frame aligner,
// so that each side stalls on its own. Depends on afa_pkg.
module afa_word_queue
  import afa_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  afa_word_t  push_word,
  output logic       full,
  input  logic       pop,
  output logic       not_empty,
  output afa_word_t  head_word
);

  afa_word_t               slots [QUEUE_DEPTH];
  logic [QUEUE_PTR_W-1:0]  wr_ptr;
  logic [QUEUE_PTR_W-1:0]  rd_ptr;
  logic [QUEUE_CNT_W-1:0]  count;
  logic                    do_push;
  logic                    do_pop;

  assign full      = (count == QUEUE_CNT_W'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head_word = slots[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  // Step a pointer with wrap at the queue depth
  function automatic logic [QUEUE_PTR_W-1:0] bump(input logic [QUEUE_PTR_W-1:0] p);
    if (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + QUEUE_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + QUEUE_CNT_W'(1);
        2'b01:   count <= count - QUEUE_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  // Store the incoming word
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_word;
    end
  end

endmodule

### hdl/afa_back.sv
// Back end of the frame aligner: tracks the X/Y/Z sequence, holds samples
// and registers triplet and sync error results. Depends on afa_pkg and
// afa_result_if.
module afa_back
  import afa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          word_valid,
  input  afa_word_t     word,
  output logic          pop,
  afa_result_if.source  result_stream
);

  afa_stage_t           stage;
  afa_stage_t           stage_next;
  logic [SAMPLE_W-1:0]  held_x;
  logic [SAMPLE_W-1:0]  held_y;
  logic [SAMPLE_W-1:0]  held_z;
  logic                 out_valid;
  logic                 emit_triplet;
  logic                 emit_error;
  logic                 load_x;
  logic                 load_y;
  logic                 load_z;

  // Take a word when the output register is free or being drained
  assign pop = word_valid && (!out_valid || result_stream.ready);

  // Next stage
  always_comb begin
    stage_next = stage;
    case (stage)
      STAGE_IDLE:   if (word.marked) stage_next = STAGE_WANT_Y;
      STAGE_FULL:   stage_next = word.marked ? STAGE_WANT_Y : STAGE_IDLE;
      STAGE_WANT_Y: stage_next = word.marked ? STAGE_IDLE : STAGE_WANT_Z;
      STAGE_WANT_Z: stage_next = word.marked ? STAGE_IDLE : STAGE_FULL;
      default:      stage_next = STAGE_IDLE;
    endcase
  end

  // Sample loads and results for the word in hand
  always_comb begin
    emit_triplet = 1'b0;
    emit_error   = 1'b0;
    load_x       = 1'b0;
    load_y       = 1'b0;
    load_z       = 1'b0;
    case (stage)
      STAGE_IDLE: begin
        load_x = word.marked;
      end
      STAGE_FULL: begin
        emit_triplet = word.marked;
        load_x       = word.marked;
        emit_error   = !word.marked;
      end
      STAGE_WANT_Y: begin
        load_y     = !word.marked;
        emit_error = word.marked;
      end
      STAGE_WANT_Z: begin
        load_z     = !word.marked;
        emit_error = word.marked;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      stage     <= STAGE_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        stage     <= stage_next;
        out_valid <= emit_triplet || emit_error;
      end else if (result_stream.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold samples and load the result register
  always_ff @(posedge clk) begin
    if (pop) begin
      if (load_x) held_x <= word.sample;
      if (load_y) held_y <= word.sample;
      if (load_z) held_z <= word.sample;
      if (emit_triplet || emit_error) begin
        result_stream.triplet_valid <= emit_triplet;
        result_stream.sync_error    <= emit_error;
        result_stream.x_value       <= emit_triplet ? signed'(held_x) : '0;
        result_stream.y_value       <= emit_triplet ? signed'(held_y) : '0;
        result_stream.z_value       <= emit_triplet ? signed'(held_z) : '0;
      end
    end
  end

  assign result_stream.valid = out_valid;

endmodule

### hdl/accel_xyz_frame_aligner.sv
// Channel        Dir  Handshake      Payload
// byte_stream    in   valid/ready    data_byte[7:0], restart
// result_stream  out  valid/ready    triplet_valid, sync_error, x/y/z_value[19:0] signed
//
// One byte is taken every cycle while the queue is not full; the third byte of
// a word enters a two-word queue, and the axis sequencer retires one queued word
// per cycle while the output is free or drained, registering any result it makes.
// Reset is synchronous and clears byte phase, queue pointers, axis stage and
// the output valid; held samples need no clearing. An output stall fills the
// queue and then drops byte_stream.ready.
//
// Top level of the frame aligner. Depends on afa_pkg, afa_ifs, afa_front,
// afa_word_queue and afa_back.
module accel_xyz_frame_aligner
  import afa_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  afa_byte_if.sink      byte_stream,
  afa_result_if.source  result_stream
);

  logic       push;
  afa_word_t  push_word;
  logic       queue_full;
  logic       pop;
  logic       queue_not_empty;
  afa_word_t  head_word;

  afa_front u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_stream (byte_stream),
    .queue_full  (queue_full),
    .push        (push),
    .push_word   (push_word)
  );

  afa_word_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_word (push_word),
    .full      (queue_full),
    .pop       (pop),
    .not_empty (queue_not_empty),
    .head_word (head_word)
  );

  afa_back u_back (
    .clk           (clk),
    .rst           (rst),
    .word_valid    (queue_not_empty),
    .word          (head_word),
    .pop           (pop),
    .result_stream (result_stream)
  );

`ifndef NO_ASSERTIONS
  // A finished word never meets a full queue
  a_no_push_when_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !queue_full)
    else $error("word pushed into full queue");

  // The back end takes only words that are present
  a_pop_needs_word: assert property (@(posedge clk) disable iff (rst)
    pop |-> queue_not_empty)
    else $error("pop from empty queue");

  // A result is either a triplet or a sync error, never both
  a_result_kind: assert property (@(posedge clk) disable iff (rst)
    result_stream.valid |-> (result_stream.triplet_valid != result_stream.sync_error))
    else $error("result carries both or neither kind");

  // A stalled result is not overwritten by a new word
  a_no_pop_on_stall: assert property (@(posedge clk) disable iff (rst)
    (result_stream.valid && !result_stream.ready) |-> !pop)
    else $error("word taken while result stalled");
`endif

endmodule
